### rtl/eatq_pkg.sv
// eatq_pkg: shared constants, types and helper functions for the euler angles to quaternion block
// no dependencies; imported by every module of the block
package eatq_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int NITER = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
	localparam int WORK_FRAC = 30;
	localparam int VW = 33;
	localparam int ZW = 26;
	localparam logic signed [VW-1:0] GAIN_INV_Q30 = 33'sd652032874;
	localparam logic signed [15:0] DEG90 = 16'sd11520;
	localparam logic signed [17:0] DEG180 = 18'sd23040;
	localparam logic signed [17:0] DEG360 = 18'sd46080;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [ZW-1:0] ang_t;

	// rotation state of one angle in flight
	typedef struct packed {
		val_t x;
		val_t y;
		ang_t z;
		logic neg;
	} rot_t;

	// all three angles of one beat in flight
	typedef struct packed {
		rot_t ax;
		rot_t ay;
		rot_t az;
	} trio_t;

	// half-angle sine and cosine of one angle, Q30
	typedef struct packed {
		val_t s;
		val_t c;
	} sc_t;

	typedef struct packed {
		sc_t sx;
		sc_t sy;
		sc_t sz;
	} sc3_t;

	// quaternion in Q30
	typedef struct packed {
		val_t x;
		val_t y;
		val_t z;
		val_t w;
	} quat_t;

	// atan(2^-i) in units of 2^-15 degree
	function automatic ang_t atan_lut(input int i);
		case (i)
			0: atan_lut = 26'sd1474560;
			1: atan_lut = 26'sd870484;
			2: atan_lut = 26'sd459940;
			3: atan_lut = 26'sd233473;
			4: atan_lut = 26'sd117189;
			5: atan_lut = 26'sd58652;
			6: atan_lut = 26'sd29333;
			7: atan_lut = 26'sd14667;
			8: atan_lut = 26'sd7334;
			9: atan_lut = 26'sd3667;
			10: atan_lut = 26'sd1833;
			11: atan_lut = 26'sd917;
			12: atan_lut = 26'sd458;
			13: atan_lut = 26'sd229;
			14: atan_lut = 26'sd115;
			15: atan_lut = 26'sd57;
			16: atan_lut = 26'sd29;
			17: atan_lut = 26'sd14;
			18: atan_lut = 26'sd7;
			19: atan_lut = 26'sd4;
			20: atan_lut = 26'sd2;
			21: atan_lut = 26'sd1;
			default: atan_lut = '0;
		endcase
	endfunction

	// range reduction of one raw angle into the cordic start state
	function automatic rot_t prep(input logic signed [15:0] raw);
		logic signed [17:0] h;
		rot_t r;
		h = 18'(raw);
		r.neg = 1'b0;
		if (h > DEG180)
			h = h - DEG360;
		if (h < -DEG180)
			h = h + DEG360;
		if (h > 18'(DEG90)) begin
			h = h - DEG180;
			r.neg = 1'b1;
		end else if (h < -18'(DEG90)) begin
			h = h + DEG180;
			r.neg = 1'b1;
		end
		r.x = GAIN_INV_Q30;
		r.y = '0;
		r.z = ZW'(h) <<< 8;
		return r;
	endfunction

	// one cordic micro-rotation
	function automatic rot_t cstep(input rot_t a, input int i);
		rot_t r;
		r = a;
		if (!a.z[ZW-1]) begin
			r.x = a.x - (a.y >>> i);
			r.y = a.y + (a.x >>> i);
			r.z = a.z - atan_lut(i);
		end else begin
			r.x = a.x + (a.y >>> i);
			r.y = a.y - (a.x >>> i);
			r.z = a.z + atan_lut(i);
		end
		return r;
	endfunction

	// q60 sum rounded to q30
	function automatic val_t rnd30(input logic signed [67:0] v);
		logic signed [67:0] t;
		t = v + (68'sd1 <<< (WORK_FRAC - 1));
		return VW'(t >>> WORK_FRAC);
	endfunction

	// q30 to output format with half-up rounding and saturation
	function automatic logic [15:0] to_out(input val_t v);
		logic signed [VW:0] t;
		logic signed [VW:0] one;
		one = (VW+1)'(1) <<< OUT_FRAC_BITS;
		t = (VW+1)'(v);
		if (WORK_FRAC > OUT_FRAC_BITS)
			t = (t + ((VW+1)'(1) <<< (WORK_FRAC - OUT_FRAC_BITS - 1)))
				>>> (WORK_FRAC - OUT_FRAC_BITS);
		if (t > one)
			t = one;
		if (t < -one)
			t = -one;
		return t[15:0];
	endfunction

endpackage

### rtl/eatq_front.sv
// eatq_front: accepts angle beats, reduces range and runs the pipelined cordic
// depends on eatq_pkg; feeds the queue in front of the product stage
module eatq_front import eatq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [47:0] in_data,
	input  logic adv,
	output logic out_valid,
	output sc3_t out_sc
);

	trio_t pipe_q [0:NITER];
	logic [NITER:0] vld_q;

	// valid bits of the cordic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NITER-1:0], in_valid};
		end
	end

	// stage zero: range reduction
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_q[0].ax <= prep(in_data[15:0]);
			pipe_q[0].ay <= prep(in_data[31:16]);
			pipe_q[0].az <= prep(in_data[47:32]);
		end
	end

	// one micro-rotation per stage
	for (genvar g = 0; g < NITER; g++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_q[g+1].ax <= cstep(pipe_q[g].ax, g);
				pipe_q[g+1].ay <= cstep(pipe_q[g].ay, g);
				pipe_q[g+1].az <= cstep(pipe_q[g].az, g);
			end
		end
	end

	// final sign fix
	always_comb begin
		out_valid = vld_q[NITER];
		out_sc.sx.s = pipe_q[NITER].ax.neg ? -pipe_q[NITER].ax.y : pipe_q[NITER].ax.y;
		out_sc.sx.c = pipe_q[NITER].ax.neg ? -pipe_q[NITER].ax.x : pipe_q[NITER].ax.x;
		out_sc.sy.s = pipe_q[NITER].ay.neg ? -pipe_q[NITER].ay.y : pipe_q[NITER].ay.y;
		out_sc.sy.c = pipe_q[NITER].ay.neg ? -pipe_q[NITER].ay.x : pipe_q[NITER].ay.x;
		out_sc.sz.s = pipe_q[NITER].az.neg ? -pipe_q[NITER].az.y : pipe_q[NITER].az.y;
		out_sc.sz.c = pipe_q[NITER].az.neg ? -pipe_q[NITER].az.x : pipe_q[NITER].az.x;
	end

endmodule

### rtl/eatq_queue.sv
// eatq_queue: short fifo between the cordic front and the product back
// depends on eatq_pkg
module eatq_queue import eatq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  sc3_t wr_data,
	input  logic rd_en,
	output logic rd_valid,
	output sc3_t rd_data,
	output logic [QAW:0] count
);

	sc3_t mem_q [0:QDEPTH-1];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= wp_q + 1'b1;
			if (rd_en)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
		end
	end

	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign count = cnt_q;

endmodule

### rtl/eatq_back.sv
// eatq_back: two pipelined hamilton products and output rounding with an output register
// depends on eatq_pkg; drains the queue
module eatq_back import eatq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sc3_t in_sc,
	output logic in_ready,
	output logic out_valid,
	output logic [63:0] out_data,
	input  logic out_ready
);

	logic v1_s1, v2_s2, v3_s3, v4_s4, ov_q;
	logic adv;
	val_t p0_s1, p1_s1, p2_s1, p3_s1;
	sc_t sy_s1, sy_s2;
	quat_t zx_s2;
	logic signed [65:0] m_s3 [0:7];
	logic [63:0] od_q;

	assign adv = !ov_q || out_ready || !v4_s4;
	assign in_ready = adv;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (adv) begin
				v1_s1 <= in_valid;
				v2_s2 <= v1_s1;
				v3_s3 <= v2_s2;
				v4_s4 <= v3_s3;
			end
			if (out_ready || !ov_q)
				ov_q <= v4_s4 && adv;
		end
	end

	// stage 1: z times x products (each has one nonzero term)
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1 <= rnd30(68'(in_sc.sz.c * in_sc.sx.s));
			p1_s1 <= rnd30(68'(in_sc.sz.s * in_sc.sx.s));
			p2_s1 <= rnd30(68'(in_sc.sz.s * in_sc.sx.c));
			p3_s1 <= rnd30(68'(in_sc.sz.c * in_sc.sx.c));
			sy_s1 <= in_sc.sy;
		end
	end

	// stage 2: assemble z*x quaternion
	always_ff @(posedge clk) begin
		if (adv) begin
			zx_s2.x <= p0_s1;
			zx_s2.y <= p1_s1;
			zx_s2.z <= p2_s1;
			zx_s2.w <= p3_s1;
			sy_s2 <= sy_s1;
		end
	end

	// stage 3: partial products with y rotation
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3[0] <= zx_s2.w * sy_s2.s;
			m_s3[1] <= zx_s2.x * sy_s2.c;
			m_s3[2] <= zx_s2.y * sy_s2.s;
			m_s3[3] <= zx_s2.z * sy_s2.c;
			m_s3[4] <= zx_s2.w * sy_s2.c;
			m_s3[5] <= zx_s2.x * sy_s2.s;
			m_s3[6] <= zx_s2.y * sy_s2.c;
			m_s3[7] <= zx_s2.z * sy_s2.s;
		end
	end

	quat_t r_s4;
	// stage 4: sums and q30 rounding
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s4.x <= rnd30(68'(m_s3[1]) - 68'(m_s3[7]));
			r_s4.y <= rnd30(68'(m_s3[0]) + 68'(m_s3[6]));
			r_s4.z <= rnd30(68'(m_s3[3]) + 68'(m_s3[5]));
			r_s4.w <= rnd30(68'(m_s3[4]) - 68'(m_s3[2]));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if ((out_ready || !ov_q) && adv)
			od_q <= {to_out(r_s4.w), to_out(r_s4.z), to_out(r_s4.y), to_out(r_s4.x)};
	end

	assign out_valid = ov_q;
	assign out_data = od_q;

endmodule

### rtl/euler_angles_to_quaternion.sv
// euler_angles_to_quaternion: top level joining cordic front, queue and product back
// depends on eatq_pkg, eatq_front, eatq_queue, eatq_back
//
// channel   dir  tdata fields (low bit up)
// s_axis    in   angle_x[15:0] angle_y[31:16] angle_z[47:32]
// m_axis    out  quat_x[15:0] quat_y[31:16] quat_z[47:32] quat_w[63:48]
//
// one beat per cycle while s_axis_tready is high; a result is valid once its input beat has passed
// range reduction at the accepting edge, 16 cordic stages, the queue, four product
// stages and the output register
// the cordic pipeline (one stage per iteration) moves only while the queue has room
// the back part stalls only on m_axis_tready; the queue holds up to three beats before
// the cordic pipeline and s_axis_tready stop
// reset clears all valid bits, pointers and the output register valid
module euler_angles_to_quaternion import eatq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // angle_x, angle_y, angle_z
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [63:0] m_axis_tdata    // quat_x, quat_y, quat_z, quat_w
);

	logic f_valid, q_valid, b_ready, adv;
	sc3_t f_sc, q_sc;
	logic [QAW:0] q_cnt;

	// front advances when queue cannot overflow from beats in flight
	assign adv = (q_cnt < (QAW+1)'(QDEPTH - 1)) || (q_valid && b_ready);
	assign s_axis_tready = adv;

	eatq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid && adv), .in_data(s_axis_tdata),
		.adv(adv), .out_valid(f_valid), .out_sc(f_sc)
	);

	eatq_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_en(f_valid && adv), .wr_data(f_sc),
		.rd_en(q_valid && b_ready), .rd_valid(q_valid), .rd_data(q_sc),
		.count(q_cnt)
	);

	eatq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_sc(q_sc), .in_ready(b_ready),
		.out_valid(m_axis_tvalid), .out_data(m_axis_tdata), .out_ready(m_axis_tready)
	);

endmodule
